@@ src/cv3_pkg.sv @@
`default_nettype none

package cv3_pkg;

    localparam int MAX_COLS    = 1024;
    localparam int SAMPLE_BITS = 16;

    localparam int LINE_DEPTH = MAX_COLS + 2;
    localparam int COL_W      = $clog2(LINE_DEPTH);
    localparam int ROW_W      = 17;

    // field and register widths
    localparam int IN_W       = 16;
    localparam int OUT_W      = 36;
    localparam int COLCNT_W   = 11;
    localparam int ROWCNT_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_ROW_W = 3 * COEF_W;
    localparam int TAPS       = 9;

    // wide enough for col_count and MAX_COLS + 1 over the whole range
    localparam int EXT_W = 16;

    localparam int PROD_W = SAMPLE_BITS + COEF_W;
    localparam int PSUM_W = PROD_W + 2;
    localparam int FULL_W = (PSUM_W + 2 > OUT_W) ? PSUM_W + 2 : OUT_W;

    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;

    typedef enum logic [2:0] {
        REG_COL_COUNT = 3'd0,
        REG_ROW_COUNT = 3'd1,
        REG_COEF_TOP  = 3'd2,
        REG_COEF_MID  = 3'd3,
        REG_COEF_BOT  = 3'd4
    } reg_idx_t;

    // tap k = 3 * window row + window column, left column first
    typedef logic [TAPS-1:0][COEF_W-1:0] coef_t;

    typedef struct packed {
        logic [COL_W-1:0] last_col;
        logic [ROW_W-1:0] last_row;
        coef_t            coef;
    } cfg_t;

    typedef struct packed {
        logic [TAPS-1:0][SAMPLE_BITS-1:0] tap;
        logic                             last;
    } win_t;

endpackage

`default_nettype wire

@@ src/cv3_if.sv @@
`default_nettype none

interface cv3_sample_if;
    logic                              valid;
    logic                              ready;
    logic signed [cv3_pkg::IN_W-1:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface cv3_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [cv3_pkg::OUT_W-1:0]  filtered;
    logic                              frame_end;

    modport source (output valid, output filtered, output frame_end, input ready);
    modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface

`default_nettype wire

@@ src/conv3x3_line_buffered.sv @@
`default_nettype none

// The line buffer is read at the accepting edge; products, row sums and the final sum are
// then registered in turn into the result on sums, and a stall on sums holds them.
// Throughput: one item per cycle unless sums stalls; the line-buffer RAM has one read and
// one write port. Border items give no result. Reset clears counters, window and pipeline
// valids; line-buffer contents stay undefined, and no result uses an unwritten entry.
module conv3x3_line_buffered
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cv3_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [cv3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [cv3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    cv3_sample_if.sink                              pixels,
    cv3_result_if.source                            sums
);

    localparam int SB = cv3_pkg::SAMPLE_BITS;

    cv3_pkg::cfg_t                  cfg;
    logic                           restart;
    logic                           in_ready;
    logic                           accept;
    logic                           mac_ready;
    cv3_pkg::win_t                  mac_win;

    logic [cv3_pkg::COL_W-1:0]      col_reg, col_next;
    logic [cv3_pkg::ROW_W-1:0]      row_reg, row_next;
    logic                           has_result;
    logic                           is_last;

    logic                           s1_valid_reg, s1_valid_next;
    logic                           s1_fresh_reg;
    logic                           s1_res_reg;
    logic                           s1_last_reg;
    logic [SB-1:0]                  s1_sample_reg;
    logic [cv3_pkg::COL_W-1:0]      s1_col_reg;
    logic [2*SB-1:0]                hold_reg;
    logic [2*SB-1:0]                mem_rdata;
    logic [2*SB-1:0]                line_word;
    logic [SB-1:0]                  line_top;
    logic [SB-1:0]                  line_mid;
    logic                           s1_adv;

    // window columns: [0..2] two columns back, [3..5] one column back; top, mid, bottom
    logic [5:0][SB-1:0]             win_reg;

    cv3_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    assign pixels.ready = in_ready;
    assign accept       = pixels.valid && in_ready;

    assign has_result = (row_reg >= cv3_pkg::ROW_W'(2)) && (col_reg >= cv3_pkg::COL_W'(2));
    assign is_last    = (row_reg == cfg.last_row) && (col_reg == cfg.last_col);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == cfg.last_col)
            begin
                col_next = '0;
                row_next = (row_reg == cfg.last_row) ? '0 : row_reg + cv3_pkg::ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + cv3_pkg::COL_W'(1);
            end
        end
    end

    assign s1_adv   = s1_valid_reg && (!s1_res_reg || mac_ready);
    assign in_ready = !s1_valid_reg || s1_adv;

    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_fresh_reg <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            s1_fresh_reg <= accept;
            if (s1_adv)
            begin
                win_reg[2:0] <= win_reg[5:3];
                win_reg[3]   <= line_top;
                win_reg[4]   <= line_mid;
                win_reg[5]   <= s1_sample_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= pixels.sample[SB-1:0];
            s1_col_reg    <= col_reg;
            s1_res_reg    <= has_result;
            s1_last_reg   <= is_last;
        end
        // keep the line word while the stage waits
        if (s1_fresh_reg)
        begin
            hold_reg <= mem_rdata;
        end
    end

    // a row is at least three columns, so a read never meets a pending write to its entry
    cv3_line_mem u_mem
    (
        .clk   (clk),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mem_rdata),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata ({line_mid, s1_sample_reg})
    );

    assign line_word = s1_fresh_reg ? mem_rdata : hold_reg;
    assign line_top  = line_word[2*SB-1:SB];
    assign line_mid  = line_word[SB-1:0];

    always_comb
    begin
        mac_win.tap[0] = win_reg[0];
        mac_win.tap[1] = win_reg[3];
        mac_win.tap[2] = line_top;
        mac_win.tap[3] = win_reg[1];
        mac_win.tap[4] = win_reg[4];
        mac_win.tap[5] = line_mid;
        mac_win.tap[6] = win_reg[2];
        mac_win.tap[7] = win_reg[5];
        mac_win.tap[8] = s1_sample_reg;
        mac_win.last   = s1_last_reg;
    end

    cv3_mac u_mac
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (cfg.coef),
        .in_valid (s1_adv && s1_res_reg),
        .in_ready (mac_ready),
        .win      (mac_win),
        .sums     (sums)
    );

endmodule

`default_nettype wire

@@ src/cv3_regs.sv @@
`default_nettype none

module cv3_regs
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [cv3_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [cv3_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [cv3_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready,
    output cv3_pkg::cfg_t                           cfg,
    output logic                                    restart
);

    cv3_pkg::reg_idx_t                       idx;
    logic                                    wr_en;
    logic [cv3_pkg::COLCNT_W-1:0]            col_count_reg;
    logic [cv3_pkg::ROWCNT_W-1:0]            row_count_reg;
    logic [2:0][cv3_pkg::COEF_ROW_W-1:0]     coef_reg;
    logic [cv3_pkg::EXT_W-1:0]               col_ext;
    logic [cv3_pkg::EXT_W-1:0]               cols_eff;
    logic [cv3_pkg::ROW_W-1:0]               rows_eff;

    assign pready = 1'b1;
    assign idx    = cv3_pkg::reg_idx_t'(paddr[5:3]);
    assign wr_en  = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= cv3_pkg::COLCNT_W'(1);
            row_count_reg <= cv3_pkg::ROWCNT_W'(1);
            coef_reg      <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                cv3_pkg::REG_COL_COUNT: col_count_reg <= pwdata[cv3_pkg::COLCNT_W-1:0];
                cv3_pkg::REG_ROW_COUNT: row_count_reg <= pwdata[cv3_pkg::ROWCNT_W-1:0];
                cv3_pkg::REG_COEF_TOP:  coef_reg[0]   <= pwdata[cv3_pkg::COEF_ROW_W-1:0];
                cv3_pkg::REG_COEF_MID:  coef_reg[1]   <= pwdata[cv3_pkg::COEF_ROW_W-1:0];
                cv3_pkg::REG_COEF_BOT:  coef_reg[2]   <= pwdata[cv3_pkg::COEF_ROW_W-1:0];
                default: ;
            endcase
        end
    end

    // a size write restarts the frame
    always_comb
    begin
        restart = 1'b0;
        if (wr_en)
        begin
            case (idx)
                cv3_pkg::REG_COL_COUNT: restart = 1'b1;
                cv3_pkg::REG_ROW_COUNT: restart = 1'b1;
                default:                restart = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            cv3_pkg::REG_COL_COUNT: prdata = cv3_pkg::APB_DATA_W'(col_count_reg);
            cv3_pkg::REG_ROW_COUNT: prdata = cv3_pkg::APB_DATA_W'(row_count_reg);
            cv3_pkg::REG_COEF_TOP:  prdata = cv3_pkg::APB_DATA_W'(coef_reg[0]);
            cv3_pkg::REG_COEF_MID:  prdata = cv3_pkg::APB_DATA_W'(coef_reg[1]);
            cv3_pkg::REG_COEF_BOT:  prdata = cv3_pkg::APB_DATA_W'(coef_reg[2]);
            default:                prdata = '0;
        endcase
    end

    // zero counts act as one, wide column counts clamp to MAX_COLS
    always_comb
    begin
        col_ext = cv3_pkg::EXT_W'(col_count_reg);
        if (col_ext == '0)
            cols_eff = cv3_pkg::EXT_W'(1);
        else if (col_ext > cv3_pkg::EXT_W'(cv3_pkg::MAX_COLS))
            cols_eff = cv3_pkg::EXT_W'(cv3_pkg::MAX_COLS);
        else
            cols_eff = col_ext;

        if (row_count_reg == '0)
            rows_eff = cv3_pkg::ROW_W'(1);
        else
            rows_eff = cv3_pkg::ROW_W'(row_count_reg);
    end

    always_comb
    begin
        cfg.last_col = cv3_pkg::COL_W'(cols_eff + cv3_pkg::EXT_W'(1));
        cfg.last_row = rows_eff + cv3_pkg::ROW_W'(1);
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cfg.coef[3*r+k] = coef_reg[r][k*cv3_pkg::COEF_W +: cv3_pkg::COEF_W];
            end
        end
    end

endmodule

`default_nettype wire

@@ src/cv3_line_mem.sv @@
`default_nettype none

// both line buffers in one word: upper row in the high half, middle row in the low half
module cv3_line_mem
(
    input  wire logic                                 clk,
    input  wire logic                                 re,
    input  wire logic [cv3_pkg::COL_W-1:0]            raddr,
    output logic      [2*cv3_pkg::SAMPLE_BITS-1:0]    rdata,
    input  wire logic                                 we,
    input  wire logic [cv3_pkg::COL_W-1:0]            waddr,
    input  wire logic [2*cv3_pkg::SAMPLE_BITS-1:0]    wdata
);

    logic [2*cv3_pkg::SAMPLE_BITS-1:0] mem [cv3_pkg::LINE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ src/cv3_mac.sv @@
`default_nettype none

// products, three row sums, final sum into the output register
module cv3_mac
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire cv3_pkg::coef_t       coef,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire cv3_pkg::win_t        win,
    cv3_result_if.source              sums
);

    logic signed [cv3_pkg::PROD_W-1:0]  prod_reg [cv3_pkg::TAPS];
    logic signed [cv3_pkg::PROD_W-1:0]  prod_next [cv3_pkg::TAPS];
    logic signed [cv3_pkg::PSUM_W-1:0]  psum_reg [3];
    logic signed [cv3_pkg::PSUM_W-1:0]  psum_next [3];
    logic signed [cv3_pkg::FULL_W-1:0]  full_sum;
    logic [cv3_pkg::OUT_W-1:0]          filtered_reg;
    logic                               last2_reg;
    logic                               last3_reg;
    logic                               frame_end_reg;

    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic out_valid_reg, out_valid_next;
    logic go4, free3, free2;

    assign go4      = !out_valid_reg || sums.ready;
    assign free3    = !v3_reg || go4;
    assign free2    = !v2_reg || free3;
    assign in_ready = free2;

    always_comb
    begin
        v2_next        = free2 ? in_valid : v2_reg;
        v3_next        = free3 ? v2_reg : v3_reg;
        out_valid_next = go4 ? v3_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v2_reg        <= v2_next;
            v3_reg        <= v3_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        for (int k = 0; k < cv3_pkg::TAPS; k++)
        begin
            prod_next[k] = $signed(win.tap[k]) * $signed(coef[k]);
        end
        for (int r = 0; r < 3; r++)
        begin
            psum_next[r] = cv3_pkg::PSUM_W'(prod_reg[3*r])
                         + cv3_pkg::PSUM_W'(prod_reg[3*r+1])
                         + cv3_pkg::PSUM_W'(prod_reg[3*r+2]);
        end
        full_sum = cv3_pkg::FULL_W'(psum_reg[0])
                 + cv3_pkg::FULL_W'(psum_reg[1])
                 + cv3_pkg::FULL_W'(psum_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (free2 && in_valid)
        begin
            prod_reg  <= prod_next;
            last2_reg <= win.last;
        end
        if (free3 && v2_reg)
        begin
            psum_reg  <= psum_next;
            last3_reg <= last2_reg;
        end
        if (go4 && v3_reg)
        begin
            filtered_reg  <= full_sum[cv3_pkg::OUT_W-1:0];
            frame_end_reg <= last3_reg;
        end
    end

    assign sums.valid     = out_valid_reg;
    assign sums.filtered  = filtered_reg;
    assign sums.frame_end = frame_end_reg;

endmodule

`default_nettype wire
